// ===== hdl/wsht_pkg.sv =====
// ----------------------------------------------------------------------------
// Window stack hit test: shared package
// Types, constants and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package wsht_pkg;

    // Table size and coordinate width.
    localparam int MAX_WINDOWS = 16;
    localparam int COORD_WIDTH = 12;
    localparam int SLOT_W      = $clog2(MAX_WINDOWS);
    localparam int COUNT_W     = 5;
    localparam int KIND_W      = 2;

    typedef logic [COORD_WIDTH-1:0] t_coord;
    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [COUNT_W-1:0]     t_count;
    typedef logic [KIND_W-1:0]      t_kind;

    // Item kinds; the fourth code means nothing and is ignored.
    localparam t_kind KIND_LOAD    = 2'd0;
    localparam t_kind KIND_CLICK   = 2'd1;
    localparam t_kind KIND_RESTACK = 2'd2;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // write the rectangle of the accepted beat
        logic restack;  // set the initial stacking order
        logic start;    // latch the click point, rewind the position
        logic step;     // advance to the next stack position
        logic emit;     // load the result register
        logic move;     // move the hit window to the front
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;       // window at the current position contains the point
        logic last;      // current position is the last active one
        logic empty;     // no active windows
        logic out_busy;  // result register is full and not taken this cycle
    } t_status;

endpackage

// ===== hdl/wsht_item_if.sv =====
// ----------------------------------------------------------------------------
// Window stack hit test: input channel
// Valid/ready channel that carries one load, click or restack item per beat.
// ----------------------------------------------------------------------------
interface wsht_item_if;
    logic                 valid;
    logic                 ready;
    wsht_pkg::t_kind      kind;
    wsht_pkg::t_slot      window_index;
    wsht_pkg::t_coord     left;
    wsht_pkg::t_coord     bottom;
    wsht_pkg::t_coord     right;
    wsht_pkg::t_coord     top;
    wsht_pkg::t_coord     point_x;
    wsht_pkg::t_coord     point_y;

    modport source (
        output valid, kind, window_index, left, bottom, right, top, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, kind, window_index, left, bottom, right, top, point_x, point_y,
        output ready
    );
endinterface

// ===== hdl/wsht_result_if.sv =====
// ----------------------------------------------------------------------------
// Window stack hit test: result channel
// Valid/ready channel that carries one click result per beat.
// ----------------------------------------------------------------------------
interface wsht_result_if;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    wsht_pkg::t_count      window_number;

    modport source (
        output valid, hit, window_number,
        input  ready
    );
    modport sink (
        input  valid, hit, window_number,
        output ready
    );
endinterface

// ===== hdl/wsht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window stack hit test: controller
// Accepts items, sequences the front-to-back scan of a click and decides
// when the result and the move to front take place.
// ----------------------------------------------------------------------------
module wsht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wsht_pkg::t_kind    i_kind,
    output logic               o_ready,
    input  wsht_pkg::t_status  i_status,
    output wsht_pkg::t_cmd     o_cmd
);

    wsht_pkg::t_state r_state;
    wsht_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsht_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            wsht_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_kind)
                        wsht_pkg::KIND_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        wsht_pkg::KIND_RESTACK: begin
                            o_cmd.restack = 1'b1;
                        end
                        wsht_pkg::KIND_CLICK: begin
                            o_cmd.start = 1'b1;
                            n_state     = wsht_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wsht_pkg::ST_SCAN: begin
                // A hit or the end of the stack finishes the click once the
                // result register has room; otherwise move one position on.
                priority if (i_status.empty || i_status.hit || i_status.last) begin
                    if (!i_status.out_busy) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.move = i_status.hit && !i_status.empty;
                        n_state    = wsht_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = wsht_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/wsht_dp.sv =====
// ----------------------------------------------------------------------------
// Window stack hit test: datapath
// Rectangle table, stacking order, scan position, point compare and the
// result register.
// ----------------------------------------------------------------------------
module wsht_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  wsht_pkg::t_count   i_cfg_data,
    input  wsht_pkg::t_slot    i_window_index,
    input  wsht_pkg::t_coord   i_left,
    input  wsht_pkg::t_coord   i_bottom,
    input  wsht_pkg::t_coord   i_right,
    input  wsht_pkg::t_coord   i_top,
    input  wsht_pkg::t_coord   i_point_x,
    input  wsht_pkg::t_coord   i_point_y,
    input  wsht_pkg::t_cmd     i_cmd,
    output wsht_pkg::t_status  o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_out_hit,
    output wsht_pkg::t_count   o_out_number
);

    // Rectangle table; entries hold nothing meaningful until loaded.
    wsht_pkg::t_coord r_left   [wsht_pkg::MAX_WINDOWS];
    wsht_pkg::t_coord r_bottom [wsht_pkg::MAX_WINDOWS];
    wsht_pkg::t_coord r_right  [wsht_pkg::MAX_WINDOWS];
    wsht_pkg::t_coord r_top    [wsht_pkg::MAX_WINDOWS];

    // Stacking order, front at position zero.
    wsht_pkg::t_slot  r_stack  [wsht_pkg::MAX_WINDOWS];

    wsht_pkg::t_count r_count;
    wsht_pkg::t_slot  r_pos;
    wsht_pkg::t_coord r_px;
    wsht_pkg::t_coord r_py;
    logic             r_out_valid;
    logic             r_out_hit;
    wsht_pkg::t_count r_out_number;

    wsht_pkg::t_count active;
    wsht_pkg::t_slot  cur_slot;
    logic             cur_hit;

    // Active window count, clamped to the table size.
    assign active = (r_count > wsht_pkg::t_count'(wsht_pkg::MAX_WINDOWS))
                  ? wsht_pkg::t_count'(wsht_pkg::MAX_WINDOWS) : r_count;

    // Point test against the window at the current position.
    assign cur_slot = r_stack[r_pos];
    assign cur_hit  = (r_left[cur_slot] <= r_px) && (r_px <= r_right[cur_slot]) &&
                      (r_bottom[cur_slot] <= r_py) && (r_py <= r_top[cur_slot]);

    assign o_status.hit      = cur_hit;
    assign o_status.empty    = (active == '0);
    assign o_status.last     = ({1'b0, r_pos} == (active - wsht_pkg::t_count'(1)));
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_hit    = r_out_hit;
    assign o_out_number = r_out_number;

    // Rectangle writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left[i_window_index]   <= i_left;
            r_bottom[i_window_index] <= i_bottom;
            r_right[i_window_index]  <= i_right;
            r_top[i_window_index]    <= i_top;
        end
    end

    // Stacking order: restack or move the hit window to the front.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < wsht_pkg::MAX_WINDOWS; p++) begin
                r_stack[p] <= wsht_pkg::t_slot'(wsht_pkg::MAX_WINDOWS - 1 - p);
            end
        end else if (i_cmd.restack) begin
            for (int p = 0; p < wsht_pkg::MAX_WINDOWS; p++) begin
                if (wsht_pkg::t_count'(p) < active) begin
                    r_stack[p] <= wsht_pkg::t_slot'(active - wsht_pkg::t_count'(p + 1));
                end else begin
                    r_stack[p] <= wsht_pkg::t_slot'(p);
                end
            end
        end else if (i_cmd.move) begin
            r_stack[0] <= cur_slot;
            for (int k = 1; k < wsht_pkg::MAX_WINDOWS; k++) begin
                if (wsht_pkg::t_slot'(k) <= r_pos) begin
                    r_stack[k] <= r_stack[k-1];
                end
            end
        end
    end

    // Window count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= wsht_pkg::t_count'(wsht_pkg::MAX_WINDOWS);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    // Click point and scan position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px  <= i_point_x;
            r_py  <= i_point_y;
            r_pos <= '0;
        end else if (i_cmd.step) begin
            r_pos <= r_pos + wsht_pkg::t_slot'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_hit    <= i_cmd.move;
            r_out_number <= i_cmd.move ? ({1'b0, cur_slot} + wsht_pkg::t_count'(1)) : '0;
        end
    end

endmodule

// ===== hdl/window_stack_click_hit_test.sv =====
// ----------------------------------------------------------------------------
// Window stack hit test with move to front
// Keeps up to sixteen window rectangles and their stacking order, tests
// clicks front to back and brings the clicked window to the front.
// ----------------------------------------------------------------------------
// Load and restack items give no result. A click is accepted, then
// examines one stack position per cycle, front to back, until it hits a
// window or reaches the last active position (the active count is
// window_count, capped at sixteen); with no window active it ends without
// a hit. Results leave through a register, so loads and restacks are still
// accepted while a result waits, and a new click stalls at its last step
// only if the previous result is still held. The user must write
// window_count through i_cfg_we/i_cfg_data only while the block idles;
// the block itself does not enforce this.
module window_stack_click_hit_test (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  wsht_pkg::t_count     i_cfg_data,
    wsht_item_if.sink            i_item,
    wsht_result_if.source        o_result
);

    wsht_pkg::t_cmd    cmd;
    wsht_pkg::t_status status;

    // Controller.
    wsht_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_kind   (i_item.kind),
        .o_ready  (i_item.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath.
    wsht_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_window_index (i_item.window_index),
        .i_left         (i_item.left),
        .i_bottom       (i_item.bottom),
        .i_right        (i_item.right),
        .i_top          (i_item.top),
        .i_point_x      (i_item.point_x),
        .i_point_y      (i_item.point_y),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_out_hit      (o_result.hit),
        .o_out_number   (o_result.window_number)
    );

    // A result is never written over one that is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !status.out_busy)
        else $error("result register overwritten");

    // A window only moves to the front together with its result beat.
    a_move_with_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.move |=> (o_result.valid && o_result.hit))
        else $error("move to front without a hit result");

    // An accepted click blocks the input while its scan runs.
    a_click_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && (i_item.kind == wsht_pkg::KIND_CLICK))
        |=> !i_item.ready)
        else $error("input accepted during a scan");

    // An ignored click reports window zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.hit) |-> (o_result.window_number == '0))
        else $error("ignored click with a window number");

endmodule

// ===== tb/wsht_click_check_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Window stack hit test: click scoreboard
// Keeps its own window table and stacking order. It works out the result of
// every accepted click and checks the result beats that leave the block.
// ----------------------------------------------------------------------------
package wsht_click_check_pkg;

    // The fourth item code is not used by the block.
    localparam wsht_pkg::t_kind KIND_UNUSED = 2'd3;

    // One input beat, field by field.
    typedef struct packed {
        wsht_pkg::t_kind  kind;
        wsht_pkg::t_slot  window_index;
        wsht_pkg::t_coord left;
        wsht_pkg::t_coord bottom;
        wsht_pkg::t_coord right;
        wsht_pkg::t_coord top;
        wsht_pkg::t_coord point_x;
        wsht_pkg::t_coord point_y;
    } t_window_item;

    // One click result beat.
    typedef struct packed {
        logic             hit;
        wsht_pkg::t_count window_number;
    } t_click_result;

    class click_scoreboard;
        wsht_pkg::t_coord win_left[wsht_pkg::MAX_WINDOWS];
        wsht_pkg::t_coord win_bottom[wsht_pkg::MAX_WINDOWS];
        wsht_pkg::t_coord win_right[wsht_pkg::MAX_WINDOWS];
        wsht_pkg::t_coord win_top[wsht_pkg::MAX_WINDOWS];
        wsht_pkg::t_slot  z_order[wsht_pkg::MAX_WINDOWS];
        wsht_pkg::t_count window_count;
        t_click_result    awaited_clicks[$];
        int unsigned      mismatches;

        // After reset the highest slot is in front.
        function new();
            mismatches   = 0;
            window_count = wsht_pkg::t_count'(wsht_pkg::MAX_WINDOWS);
            for (int p = 0; p < wsht_pkg::MAX_WINDOWS; p++) begin
                z_order[p]    = wsht_pkg::t_slot'(wsht_pkg::MAX_WINDOWS - 1 - p);
                win_left[p]   = '0;
                win_bottom[p] = '0;
                win_right[p]  = '0;
                win_top[p]    = '0;
            end
        endfunction

        // Counts above the table size act as the table size.
        function int active_windows();
            return (window_count > wsht_pkg::MAX_WINDOWS) ? wsht_pkg::MAX_WINDOWS
                                                          : int'(window_count);
        endfunction

        // Inclusive rectangle test; an inverted rectangle holds no point.
        function bit covers(wsht_pkg::t_slot s, wsht_pkg::t_coord x, wsht_pkg::t_coord y);
            return win_left[s] <= x && x <= win_right[s] &&
                   win_bottom[s] <= y && y <= win_top[s];
        endfunction

        // Applies one accepted beat and queues the result a click will give.
        function void apply_item(t_window_item it);
            int              n;
            wsht_pkg::t_slot s;
            t_click_result   res;
            n   = active_windows();
            res = '0;
            case (it.kind)
                wsht_pkg::KIND_LOAD: begin
                    win_left[it.window_index]   = it.left;
                    win_bottom[it.window_index] = it.bottom;
                    win_right[it.window_index]  = it.right;
                    win_top[it.window_index]    = it.top;
                end
                wsht_pkg::KIND_RESTACK: begin
                    // Active positions get the active slots, highest in front;
                    // the rest keep their own slot so the order stays whole.
                    for (int p = 0; p < wsht_pkg::MAX_WINDOWS; p++) begin
                        z_order[p] = (p < n) ? wsht_pkg::t_slot'(n - 1 - p)
                                             : wsht_pkg::t_slot'(p);
                    end
                end
                wsht_pkg::KIND_CLICK: begin
                    // Front to back; the first window hit moves to the front
                    // and the ones passed over slide back by one.
                    for (int p = 0; p < n && !res.hit; p++) begin
                        s = z_order[p];
                        if (covers(s, it.point_x, it.point_y)) begin
                            for (int k = p; k > 0; k--) begin
                                z_order[k] = z_order[k-1];
                            end
                            z_order[0]        = s;
                            res.hit           = 1'b1;
                            res.window_number = wsht_pkg::t_count'(s)
                                              + wsht_pkg::t_count'(1);
                        end
                    end
                    awaited_clicks.push_back(res);
                end
                default: begin
                end
            endcase
        endfunction

        // Prints one line per mismatch and counts it.
        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        // Compares a result beat with the oldest click still waiting.
        task check_click(logic hit, wsht_pkg::t_count window_number);
            t_click_result want;
            if (awaited_clicks.size() == 0) begin
                report("result beat with no click waiting");
            end else begin
                want = awaited_clicks.pop_front();
                if (hit !== want.hit) begin
                    report($sformatf("hit is %b, expected %b", hit, want.hit));
                end
                if (window_number !== want.window_number) begin
                    report($sformatf("window_number is %0d, expected %0d",
                                     window_number, want.window_number));
                end
            end
        endtask
    endclass

endpackage

// ===== tb/window_stack_click_hit_test_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Window stack hit test: testbench
// Loads window rectangles, restacks and clicks through the item channel with
// random stalls on both sides, over several window counts, and checks every
// click result against the scoreboard's own window stack.
// ----------------------------------------------------------------------------
module window_stack_click_hit_test_test;

    localparam int CLK_PERIOD      = 12;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 178;
    localparam int COORD_MAX       = (1 << wsht_pkg::COORD_WIDTH) - 1;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n;
    logic                                  i_cfg_we;
    wsht_pkg::t_count                      i_cfg_data;
    int unsigned                           send_idle_pct;
    int unsigned                           recv_idle_pct;
    wsht_click_check_pkg::click_scoreboard board;

    wsht_item_if   item_bus();
    wsht_result_if result_bus();

    window_stack_click_hit_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_bus),
        .o_result   (result_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // The receiver changes its ready at falling edges.
    always @(negedge i_clk) begin
        result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result beats are taken at rising edges.
    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            board.check_click(result_bus.hit, result_bus.window_number);
        end
    end

    function automatic wsht_click_check_pkg::t_window_item compose_item(
        wsht_pkg::t_kind kind, int slot, int lo_x, int lo_y,
        int hi_x, int hi_y, int x, int y);
        wsht_click_check_pkg::t_window_item it;
        it.kind         = kind;
        it.window_index = wsht_pkg::t_slot'(slot);
        it.left         = wsht_pkg::t_coord'(lo_x);
        it.bottom       = wsht_pkg::t_coord'(lo_y);
        it.right        = wsht_pkg::t_coord'(hi_x);
        it.top          = wsht_pkg::t_coord'(hi_y);
        it.point_x      = wsht_pkg::t_coord'(x);
        it.point_y      = wsht_pkg::t_coord'(y);
        return it;
    endfunction

    // An ordered span: half of them wide, half of them narrow.
    function automatic void random_span(output wsht_pkg::t_coord lo,
                                        output wsht_pkg::t_coord hi);
        int a;
        int b;
        a = $urandom_range(COORD_MAX);
        if ($urandom_range(1) == 1) begin
            b = $urandom_range(COORD_MAX);
        end else begin
            b = a + $urandom_range(300);
            if (b > COORD_MAX) b = COORD_MAX;
        end
        lo = wsht_pkg::t_coord'((a < b) ? a : b);
        hi = wsht_pkg::t_coord'((a < b) ? b : a);
    endfunction

    // Mostly clicks, most of them aimed inside an active window.
    function automatic wsht_click_check_pkg::t_window_item random_item();
        wsht_click_check_pkg::t_window_item it;
        int                                 roll;
        int                                 n;
        wsht_pkg::t_slot                    s;
        it = compose_item(wsht_pkg::KIND_LOAD, $urandom_range(wsht_pkg::MAX_WINDOWS - 1),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
        roll = $urandom_range(99);
        if (roll < 18) begin
            if ($urandom_range(99) < 85) begin
                random_span(it.left, it.right);
                random_span(it.bottom, it.top);
            end
        end else if (roll < 22) begin
            it.kind = wsht_pkg::KIND_RESTACK;
        end else if (roll < 25) begin
            it.kind = wsht_click_check_pkg::KIND_UNUSED;
        end else begin
            it.kind = wsht_pkg::KIND_CLICK;
            n = board.active_windows();
            if (n > 0 && $urandom_range(99) < 75) begin
                s = board.z_order[$urandom_range(n - 1)];
                if (board.win_left[s] <= board.win_right[s] &&
                    board.win_bottom[s] <= board.win_top[s]) begin
                    it.point_x = wsht_pkg::t_coord'(
                        $urandom_range(board.win_right[s], board.win_left[s]));
                    it.point_y = wsht_pkg::t_coord'(
                        $urandom_range(board.win_top[s], board.win_bottom[s]));
                end
            end
        end
        return it;
    endfunction

    // Called and returns just after a falling edge; valid stays up after the
    // beat so back-to-back beats need no second assignment in one step.
    task automatic drive_beat(input wsht_click_check_pkg::t_window_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.kind         <= it.kind;
        item_bus.window_index <= it.window_index;
        item_bus.left         <= it.left;
        item_bus.bottom       <= it.bottom;
        item_bus.right        <= it.right;
        item_bus.top          <= it.top;
        item_bus.point_x      <= it.point_x;
        item_bus.point_y      <= it.point_y;
        do @(posedge i_clk); while (item_bus.ready !== 1'b1);
        board.apply_item(it);
        @(negedge i_clk);
    endtask

    // Sender pauses until every click result has come back.
    task automatic hold_until_drained();
        item_bus.valid <= 1'b0;
        do @(negedge i_clk); while (board.awaited_clicks.size() != 0);
    endtask

    // Drains every click result, then waits with the sender idle.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window_count(input int value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= wsht_pkg::t_count'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.window_count = wsht_pkg::t_count'(value);
    endtask

    // Time limit for a run that hangs.
    initial begin
        #(10_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        wsht_click_check_pkg::t_window_item it;
        int                                 done;
        int                                 count;
        int                                 phase_counts[PHASES] = '{16, 1, 31, 0, 9, -1,
                                                                     16, 5, 12};

        board                 = new();
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_data            = '0;
        item_bus.valid        = 1'b0;
        item_bus.kind         = wsht_pkg::KIND_LOAD;
        item_bus.window_index = '0;
        item_bus.left         = '0;
        item_bus.bottom       = '0;
        item_bus.right        = '0;
        item_bus.top          = '0;
        item_bus.point_x      = '0;
        item_bus.point_y      = '0;
        result_bus.ready      = 1'b0;
        send_idle_pct         = 27;
        recv_idle_pct         = 57;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed part on four windows: full screen, inverted in x,
        // inverted in y, and the upper right quarter.
        write_window_count(4);
        drive_beat(compose_item(wsht_pkg::KIND_LOAD, 0, 0, 0, COORD_MAX, COORD_MAX, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_LOAD, 1, COORD_MAX, 0, 0, COORD_MAX, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_LOAD, 2, 0, COORD_MAX, COORD_MAX, 0, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_LOAD, 3, 'h800, 'h800, COORD_MAX, COORD_MAX,
                                0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_RESTACK, 0, 0, 0, 0, 0, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, COORD_MAX, COORD_MAX));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, 'h800, 'h800));
        drive_beat(compose_item(wsht_click_check_pkg::KIND_UNUSED, 15, COORD_MAX, COORD_MAX,
                                COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        drive_beat(compose_item(wsht_pkg::KIND_LOAD, 15, 'h555, 'h555, 'hAAA, 'hAAA,
                                'hAAA, 'h555));
        drive_beat(compose_item(wsht_pkg::KIND_LOAD, 0, 'h555, 'hAAA, 'h555, 'hAAA, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, 'h555, 'hAAA));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, 'h554, 'hAAA));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, COORD_MAX, 'h800));

        // No active windows: clicks are ignored and restack keeps every slot.
        write_window_count(0);
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_RESTACK, 0, 0, 0, 0, 0, 0, 0));

        // A single active window.
        write_window_count(1);
        drive_beat(compose_item(wsht_pkg::KIND_RESTACK, 0, 0, 0, 0, 0, 0, 0));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, 'h555, 'hAAA));
        drive_beat(compose_item(wsht_pkg::KIND_CLICK, 0, 0, 0, 0, 0, COORD_MAX, COORD_MAX));

        // Random phases, each with its own window count and one of three stall patterns.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 3)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            count = (phase_counts[phase] < 0) ? $urandom_range(wsht_pkg::MAX_WINDOWS, 1)
                                              : phase_counts[phase];
            write_window_count(count);
            // Every slot gets a rectangle before the first deep scan.
            if (phase == 0) begin
                for (int slot = 0; slot < wsht_pkg::MAX_WINDOWS; slot++) begin
                    it = random_item();
                    it.kind         = wsht_pkg::KIND_LOAD;
                    it.window_index = wsht_pkg::t_slot'(slot);
                    drive_beat(it);
                end
            end
            done = 0;
            while (done < ITEMS_PER_PHASE) begin
                it = random_item();
                if ($urandom_range(99) < 2) hold_until_drained();
                drive_beat(it);
                if (it.kind != wsht_click_check_pkg::KIND_UNUSED) done++;
            end
        end

        settle();
        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
